// ===== design/dadc_pkg.sv =====
package dadc_pkg;

   // converter sample width and scale
   localparam int SAMPLE_W       = 10;
   localparam int ADC_FULL_SCALE = 1023;

   // pulse-width scaling denominators
   localparam int SPEED_FULL = 99;
   localparam int ANGLE_FULL = 180;

   localparam int WINDOW_DEF = 10;

   localparam logic [SAMPLE_W-1:0] SPEED_RESET_LEVEL = 10'd512;
   localparam logic [SAMPLE_W-1:0] ANGLE_RESET_LEVEL = 10'd0;
   localparam int SERVO_ANGLE_SHIFT = 90;

   // quotient width of the window scaling (covers 1023 and more)
   localparam int LANE_Q_W  = 11;
   localparam int PULSE_W   = 16;
   localparam int PULSE_NUM_W = 24;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SPEED_SPAN      = 3'd0,
      CSR_SPEED_OFFSET    = 3'd1,
      CSR_ANGLE_SPAN      = 3'd2,
      CSR_ANGLE_OFFSET    = 3'd3,
      CSR_MOTOR_TICK_SPAN = 3'd4,
      CSR_SERVO_TICK_SPAN = 3'd5,
      CSR_SERVO_TICK_BASE = 3'd6
   } csr_index_type;

   localparam logic [7:0]  SPEED_SPAN_RST      = 8'd198;
   localparam logic [6:0]  SPEED_OFFSET_RST    = 7'd99;
   localparam logic [7:0]  ANGLE_SPAN_RST      = 8'd180;
   localparam logic [6:0]  ANGLE_OFFSET_RST    = 7'd90;
   localparam logic [15:0] MOTOR_TICK_SPAN_RST = 16'd1999;
   localparam logic [15:0] SERVO_TICK_SPAN_RST = 16'd9000;
   localparam logic [15:0] SERVO_TICK_BASE_RST = 16'd2999;

   typedef enum logic [1:0] {
      DRIVE_STOP     = 2'd0,
      DRIVE_POSITIVE = 2'd1,
      DRIVE_NEGATIVE = 2'd2
   } drive_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] value;
   } lane_out_type;

   typedef struct packed {
      logic               valid;
      logic [7:0]         speed_value;
      logic [6:0]         speed_magnitude;
      logic [7:0]         angle_value;
      logic [7:0]         angle_unsigned;
      logic [PULSE_W-1:0] motor_pulse;
      logic [PULSE_W-1:0] servo_pulse;
      drive_type          bridge_drive;
   } merge_out_type;

endpackage

// ===== design/dadc_cdiv.sv =====
// Unsigned divide by a constant: reciprocal multiply, then one correction step.
module dadc_cdiv import dadc_pkg::*; #(
   parameter int NUM_W = 24,
   parameter int DEN   = 99,
   parameter int Q_W   = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] num,
   output logic             out_valid,
   output logic [Q_W-1:0]   quot
);

   localparam logic [NUM_W:0]   RECIP = (NUM_W+1)'((64'd1 << NUM_W) / 64'(DEN));
   localparam logic [NUM_W-1:0] DEN_V = NUM_W'(DEN);

   logic [2*NUM_W:0] prod_ff, prod_in;
   logic [NUM_W-1:0] num1_ff, num2_ff, num3_ff;
   logic [NUM_W-1:0] q0_ff, q0_in, q1_ff;
   logic [NUM_W-1:0] qd_ff, qd_in;
   logic [NUM_W-1:0] rem;
   logic [Q_W-1:0]   quot_ff, quot_in;
   logic             v1_ff, v2_ff, v3_ff, v4_ff;

   always_comb begin
      prod_in = num * RECIP;
      q0_in   = prod_ff[2*NUM_W-1:NUM_W];
      qd_in   = q0_ff * DEN_V;
      rem     = num3_ff - qd_ff;
      quot_in = Q_W'(q1_ff + NUM_W'(rem >= DEN_V));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // Carry the dividend and the estimate alongside the product stages.
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      num1_ff <= num;
      q0_ff   <= q0_in;
      qd_ff   <= qd_in;
      num2_ff <= num1_ff;
      num3_ff <= num2_ff;
      q1_ff   <= q0_ff;
      quot_ff <= quot_in;
   end

   assign out_valid = v4_ff;
   assign quot      = quot_ff;

endmodule

// ===== design/dadc_lane.sv =====
// One channel: sample ring, running sum, scaling with round half up, offset, saturate.
module dadc_lane import dadc_pkg::*; #(
   parameter int                  WINDOW      = WINDOW_DEF,
   parameter logic [SAMPLE_W-1:0] RESET_LEVEL = '0,
   localparam int                 SLOT_W      = $clog2(WINDOW)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [SLOT_W-1:0]   slot,
   input  logic [SAMPLE_W-1:0] sample,
   input  logic [7:0]          span,
   input  logic [6:0]          offset,
   output lane_out_type        result
);

   localparam int SUM_W  = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);
   localparam int PROD_W = SUM_W + 8;
   localparam int NUM_W  = PROD_W + 2;
   localparam int HALF   = WINDOW * ADC_FULL_SCALE;
   localparam int DEN    = 2 * WINDOW * ADC_FULL_SCALE;
   localparam logic [SUM_W-1:0] SUM_RST = SUM_W'(WINDOW * int'(RESET_LEVEL));
   localparam logic signed [LANE_Q_W:0] SAT_HI = 127;
   localparam logic signed [LANE_Q_W:0] SAT_LO = -128;

   logic [SAMPLE_W-1:0] ring_mem [WINDOW];
   logic [WINDOW-1:0]   filled_ff;

   logic [SAMPLE_W-1:0] old_data_ff;
   logic                old_filled_ff;
   logic [SAMPLE_W-1:0] sample_ff;
   logic [SAMPLE_W-1:0] old_level;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [NUM_W-1:0]    num_ff, num_in;
   logic                load_ff, sum_vld_ff, prod_vld_ff, num_vld_ff, value_vld_ff;
   logic                div_valid;
   logic [LANE_Q_W-1:0] quot;
   logic signed [LANE_Q_W:0] diff;
   logic [7:0]          value_ff, value_in;

   // ring: read the oldest entry and overwrite it in the same cycle
   always_ff @(posedge clock) begin
      if (start) begin
         ring_mem[slot] <= sample;
         old_data_ff    <= ring_mem[slot];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= '0;
      end else if (start) begin
         filled_ff[slot] <= 1'b1;
      end
   end

   always_comb begin
      old_level = old_filled_ff ? old_data_ff : RESET_LEVEL;
      sum_in    = sum_ff - SUM_W'(old_level) + SUM_W'(sample_ff);
      prod_in   = sum_ff * span;
      num_in    = {1'b0, prod_ff, 1'b0} + NUM_W'(HALF);
      diff      = $signed({1'b0, quot}) - $signed((LANE_Q_W+1)'(offset));
      if (diff > SAT_HI) begin
         value_in = 8'(SAT_HI);
      end else if (diff < SAT_LO) begin
         value_in = 8'(SAT_LO);
      end else begin
         value_in = 8'(diff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= SUM_RST;
         load_ff      <= 1'b0;
         sum_vld_ff   <= 1'b0;
         prod_vld_ff  <= 1'b0;
         num_vld_ff   <= 1'b0;
         value_vld_ff <= 1'b0;
      end else begin
         load_ff      <= start;
         sum_vld_ff   <= load_ff;
         prod_vld_ff  <= sum_vld_ff;
         num_vld_ff   <= prod_vld_ff;
         value_vld_ff <= div_valid;
         if (load_ff) begin
            sum_ff <= sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         sample_ff     <= sample;
         old_filled_ff <= filled_ff[slot];
      end
      prod_ff <= prod_in;
      num_ff  <= num_in;
      if (div_valid) begin
         value_ff <= value_in;
      end
   end

   dadc_cdiv #(
      .NUM_W (NUM_W),
      .DEN   (DEN),
      .Q_W   (LANE_Q_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (num_vld_ff),
      .num       (num_ff),
      .out_valid (div_valid),
      .quot      (quot)
   );

   assign result.valid = value_vld_ff;
   assign result.value = value_ff;

endmodule

// ===== design/dadc_merge.sv =====
// Combine both lane settings into magnitude, pulse widths and bridge direction.
module dadc_merge import dadc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [7:0]         speed,
   input  logic [7:0]         angle,
   input  logic [6:0]         angle_offset,
   input  logic [15:0]        motor_span,
   input  logic [15:0]        servo_span,
   input  logic [15:0]        servo_base,
   output merge_out_type      result
);

   logic [7:0]               speed_ff, angle_ff, angle_uns_ff, angle_uns_in;
   logic [7:0]               mag_ff, mag_in;
   logic signed [8:0]        shift_ff, shift_in;
   drive_type                drive_ff, drive_in;
   logic [PULSE_NUM_W-1:0]   motor_prod_ff, motor_prod_in, motor_num_ff;
   logic signed [25:0]       servo_prod_ff, servo_prod_in;
   logic [PULSE_NUM_W-1:0]   servo_abs_ff, servo_abs_in;
   logic                     servo_neg_ff;
   logic                     a_vld_ff, b_vld_ff, c_vld_ff, d_vld_ff;
   logic                     motor_div_vld, servo_div_vld;
   logic [PULSE_W-1:0]       motor_q, servo_q, servo_sq;
   logic [PULSE_W-1:0]       motor_ff, servo_ff, servo_in;

   always_comb begin
      mag_in       = $signed(speed) < 0 ? 8'(-$signed(speed)) : speed;
      shift_in     = 9'($signed(angle)) + 9'(SERVO_ANGLE_SHIFT);
      angle_uns_in = angle + 8'(angle_offset);
      if ($signed(speed) > 0) begin
         drive_in = DRIVE_POSITIVE;
      end else if ($signed(speed) < 0) begin
         drive_in = DRIVE_NEGATIVE;
      end else begin
         drive_in = DRIVE_STOP;
      end
      motor_prod_in = mag_ff * motor_span;
      servo_prod_in = shift_ff * $signed({1'b0, servo_span});
      servo_abs_in  = servo_prod_ff[25] ? PULSE_NUM_W'(-servo_prod_ff)
                                        : PULSE_NUM_W'(servo_prod_ff);
      // truncate toward zero: divide the magnitude, then restore the sign
      servo_sq = servo_neg_ff ? PULSE_W'(-servo_q) : servo_q;
      servo_in = servo_sq + servo_base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= start;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= motor_div_vld & servo_div_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         speed_ff     <= speed;
         angle_ff     <= angle;
         mag_ff       <= mag_in;
         shift_ff     <= shift_in;
         angle_uns_ff <= angle_uns_in;
         drive_ff     <= drive_in;
      end
      motor_prod_ff <= motor_prod_in;
      servo_prod_ff <= servo_prod_in;
      motor_num_ff  <= motor_prod_ff;
      servo_abs_ff  <= servo_abs_in;
      servo_neg_ff  <= servo_prod_ff[25];
      if (servo_div_vld) begin
         motor_ff <= motor_q;
         servo_ff <= servo_in;
      end
   end

   dadc_cdiv #(
      .NUM_W (PULSE_NUM_W),
      .DEN   (SPEED_FULL),
      .Q_W   (PULSE_W)
   ) u_motor_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_vld_ff),
      .num       (motor_num_ff),
      .out_valid (motor_div_vld),
      .quot      (motor_q)
   );

   dadc_cdiv #(
      .NUM_W (PULSE_NUM_W),
      .DEN   (ANGLE_FULL),
      .Q_W   (PULSE_W)
   ) u_servo_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_vld_ff),
      .num       (servo_abs_ff),
      .out_valid (servo_div_vld),
      .quot      (servo_q)
   );

   always_comb begin
      result.valid           = d_vld_ff;
      result.speed_value     = speed_ff;
      result.speed_magnitude = mag_ff[6:0];
      result.angle_value     = angle_ff;
      result.angle_unsigned  = angle_uns_ff;
      result.motor_pulse     = motor_ff;
      result.servo_pulse     = servo_ff;
      result.bridge_drive    = drive_ff;
   end

endmodule

// ===== design/dual_adc_average_to_pwm.sv =====
// A new req transaction is taken only when no item is in flight and the holding
//   slot is empty; the two lane pipelines and the pulse stage each run one item
//   at a time (reciprocal-multiply dividers).
// A finished result may wait on rsp_ready while the next req transaction runs.
// Reset (synchronous): configuration returns to defaults, the rings read as
//   their reset levels through per-entry fill bits, no clearing pass.
module dual_adc_average_to_pwm import dadc_pkg::*; #(
   parameter int WINDOW = WINDOW_DEF
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_W-1:0]    req_speed_sample,
   input  logic [SAMPLE_W-1:0]    req_angle_sample,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [7:0]      rsp_speed_value,
   output logic [6:0]             rsp_speed_magnitude,
   output logic signed [7:0]      rsp_angle_value,
   output logic [7:0]             rsp_angle_unsigned,
   output logic [PULSE_W-1:0]     rsp_motor_pulse,
   output logic [PULSE_W-1:0]     rsp_servo_pulse,
   output logic [1:0]             rsp_bridge_drive,

   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int SLOT_W = $clog2(WINDOW);

   // configuration registers
   logic [7:0]  speed_span_ff, angle_span_ff;
   logic [6:0]  speed_offset_ff, angle_offset_ff;
   logic [15:0] motor_span_ff, servo_span_ff, servo_base_ff;

   // control
   logic              req_accept;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              busy_ff, busy_in;
   logic              pend_valid_ff, pend_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              pend_move;
   merge_out_type     pend_ff, rsp_ff;

   lane_out_type      speed_res, angle_res;
   merge_out_type     merge_res;

   // Configuration writes land immediately; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_span_ff   <= SPEED_SPAN_RST;
         speed_offset_ff <= SPEED_OFFSET_RST;
         angle_span_ff   <= ANGLE_SPAN_RST;
         angle_offset_ff <= ANGLE_OFFSET_RST;
         motor_span_ff   <= MOTOR_TICK_SPAN_RST;
         servo_span_ff   <= SERVO_TICK_SPAN_RST;
         servo_base_ff   <= SERVO_TICK_BASE_RST;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_SPEED_SPAN:      speed_span_ff   <= csr_write_data[7:0];
            CSR_SPEED_OFFSET:    speed_offset_ff <= csr_write_data[6:0];
            CSR_ANGLE_SPAN:      angle_span_ff   <= csr_write_data[7:0];
            CSR_ANGLE_OFFSET:    angle_offset_ff <= csr_write_data[6:0];
            CSR_MOTOR_TICK_SPAN: motor_span_ff   <= csr_write_data;
            CSR_SERVO_TICK_SPAN: servo_span_ff   <= csr_write_data;
            CSR_SERVO_TICK_BASE: servo_base_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Take a new transaction when no item is in flight and the holding
   // slot behind the merge stage is empty; the output register may still
   // be waiting on rsp_ready.
   assign req_ready  = !busy_ff && !pend_valid_ff;
   assign req_accept = req_valid && req_ready;

   // Advance the shared write slot once per transaction, wrapping at WINDOW.
   always_comb begin
      if (slot_ff == SLOT_W'(WINDOW - 1)) begin
         slot_in = '0;
      end else begin
         slot_in = slot_ff + 1'b1;
      end
   end

   // Item bookkeeping: busy from acceptance until the merge result is parked,
   // then hand the parked result to the output register when it frees up.
   always_comb begin
      pend_move     = pend_valid_ff && (!rsp_valid_ff || rsp_ready);
      busy_in       = req_accept ? 1'b1 : (merge_res.valid ? 1'b0 : busy_ff);
      pend_valid_in = merge_res.valid ? 1'b1 : (pend_move ? 1'b0 : pend_valid_ff);
      if (pend_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff       <= '0;
         busy_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_accept) begin
            slot_ff <= slot_in;
         end
         busy_ff       <= busy_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload: park the merge result, then copy it to the output register.
   always_ff @(posedge clock) begin
      if (merge_res.valid) begin
         pend_ff <= merge_res;
      end
      if (pend_move) begin
         rsp_ff <= pend_ff;
      end
   end

   // Speed and angle lanes run side by side on the two samples of a transaction.
   dadc_lane #(
      .WINDOW      (WINDOW),
      .RESET_LEVEL (SPEED_RESET_LEVEL)
   ) u_speed_lane (
      .clock  (clock),
      .reset  (reset),
      .start  (req_accept),
      .slot   (slot_ff),
      .sample (req_speed_sample),
      .span   (speed_span_ff),
      .offset (speed_offset_ff),
      .result (speed_res)
   );

   dadc_lane #(
      .WINDOW      (WINDOW),
      .RESET_LEVEL (ANGLE_RESET_LEVEL)
   ) u_angle_lane (
      .clock  (clock),
      .reset  (reset),
      .start  (req_accept),
      .slot   (slot_ff),
      .sample (req_angle_sample),
      .span   (angle_span_ff),
      .offset (angle_offset_ff),
      .result (angle_res)
   );

   // Both lanes finish in the same cycle; start the merge on their joint done.
   dadc_merge u_merge (
      .clock        (clock),
      .reset        (reset),
      .start        (speed_res.valid && angle_res.valid),
      .speed        (speed_res.value),
      .angle        (angle_res.value),
      .angle_offset (angle_offset_ff),
      .motor_span   (motor_span_ff),
      .servo_span   (servo_span_ff),
      .servo_base   (servo_base_ff),
      .result       (merge_res)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_speed_value     = $signed(rsp_ff.speed_value);
   assign rsp_speed_magnitude = rsp_ff.speed_magnitude;
   assign rsp_angle_value     = $signed(rsp_ff.angle_value);
   assign rsp_angle_unsigned  = rsp_ff.angle_unsigned;
   assign rsp_motor_pulse     = rsp_ff.motor_pulse;
   assign rsp_servo_pulse     = rsp_ff.servo_pulse;
   assign rsp_bridge_drive    = rsp_ff.bridge_drive;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import dadc_pkg::*;

   // Settle time before a register write, counted while no result is pending.
   localparam int SETTLE_CYCLES = 24;
   // Cycles to keep watching after the last result, for stray transactions.
   localparam int TAIL_CYCLES   = 40;
   // Watchdog: cycles with no transaction on any port before the run is dropped.
   localparam int STALL_LIMIT   = 2000;
   // Index past the last register; the block must ignore writes to it.
   localparam logic [CSR_INDEX_W-1:0] CSR_NO_REGISTER = 3'd7;

   typedef enum {STEP_SAMPLE, STEP_CSR, STEP_DRAIN} step_kind_type;

   // One entry of the stimulus script: a sample pair, a register write, or a
   // pause until every pending result has come back.
   typedef struct {
      step_kind_type          kind;
      logic [SAMPLE_W-1:0]    speed;
      logic [SAMPLE_W-1:0]    angle;
      int                     gap;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } step_type;

   // Expected contents of one rsp transaction.
   typedef struct {
      logic signed [7:0]  speed_value;
      logic [6:0]         speed_magnitude;
      logic signed [7:0]  angle_value;
      logic [7:0]         angle_unsigned;
      logic [PULSE_W-1:0] motor_pulse;
      logic [PULSE_W-1:0] servo_pulse;
      drive_type          bridge_drive;
   } pwm_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [SAMPLE_W-1:0]    req_speed_sample = '0;
   logic [SAMPLE_W-1:0]    req_angle_sample = '0;

   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic signed [7:0]      rsp_speed_value;
   logic [6:0]             rsp_speed_magnitude;
   logic signed [7:0]      rsp_angle_value;
   logic [7:0]             rsp_angle_unsigned;
   logic [PULSE_W-1:0]     rsp_motor_pulse;
   logic [PULSE_W-1:0]     rsp_servo_pulse;
   logic [1:0]             rsp_bridge_drive;

   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   dual_adc_average_to_pwm uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_speed_sample    (req_speed_sample),
      .req_angle_sample    (req_angle_sample),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_speed_value     (rsp_speed_value),
      .rsp_speed_magnitude (rsp_speed_magnitude),
      .rsp_angle_value     (rsp_angle_value),
      .rsp_angle_unsigned  (rsp_angle_unsigned),
      .rsp_motor_pulse     (rsp_motor_pulse),
      .rsp_servo_pulse     (rsp_servo_pulse),
      .rsp_bridge_drive    (rsp_bridge_drive),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow copy of the block: configuration, both sample rings, window sums.
   // ---------------------------------------------------------------------
   int cfg_speed_span;
   int cfg_speed_offset;
   int cfg_angle_span;
   int cfg_angle_offset;
   int cfg_motor_span;
   int cfg_servo_span;
   int cfg_servo_base;

   int speed_ring [WINDOW_DEF];
   int angle_ring [WINDOW_DEF];
   int ring_slot;
   int speed_total;
   int angle_total;

   step_type       stimulus [$];
   pwm_result_type pending_outputs [$];

   int mismatch_count = 0;
   int quiet_cycles   = 0;
   int drained_cycles = 0;

   // Set at each rising edge when the channel moved a transaction.
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;

   task automatic load_defaults();
      cfg_speed_span   = int'(SPEED_SPAN_RST);
      cfg_speed_offset = int'(SPEED_OFFSET_RST);
      cfg_angle_span   = int'(ANGLE_SPAN_RST);
      cfg_angle_offset = int'(ANGLE_OFFSET_RST);
      cfg_motor_span   = int'(MOTOR_TICK_SPAN_RST);
      cfg_servo_span   = int'(SERVO_TICK_SPAN_RST);
      cfg_servo_base   = int'(SERVO_TICK_BASE_RST);
      for (int i = 0; i < WINDOW_DEF; i++) begin
         speed_ring[i] = int'(SPEED_RESET_LEVEL);
         angle_ring[i] = int'(ANGLE_RESET_LEVEL);
      end
      ring_slot   = 0;
      speed_total = int'(SPEED_RESET_LEVEL) * WINDOW_DEF;
      angle_total = int'(ANGLE_RESET_LEVEL) * WINDOW_DEF;
   endtask

   // Window sum to a signed setting: scale, round half up, offset, clamp to 8 bits.
   function automatic longint window_setting(longint total, longint span, longint offset);
      longint setting;
      setting = (2 * total * span + WINDOW_DEF * ADC_FULL_SCALE)
                / (2 * WINDOW_DEF * ADC_FULL_SCALE) - offset;
      if (setting > 127)
         setting = 127;
      if (setting < -128)
         setting = -128;
      return setting;
   endfunction

   // Push one sample pair into the rings and derive the full set of outputs.
   function automatic pwm_result_type average_to_pwm(logic [SAMPLE_W-1:0] speed_in,
                                                     logic [SAMPLE_W-1:0] angle_in);
      pwm_result_type outcome;
      longint         speed_set;
      longint         angle_set;
      longint         magnitude;
      longint         motor_ticks;
      longint         servo_ticks;
      speed_total = speed_total - speed_ring[ring_slot] + int'(speed_in);
      angle_total = angle_total - angle_ring[ring_slot] + int'(angle_in);
      speed_ring[ring_slot] = int'(speed_in);
      angle_ring[ring_slot] = int'(angle_in);
      ring_slot = (ring_slot == WINDOW_DEF - 1) ? 0 : ring_slot + 1;

      speed_set = window_setting(speed_total, cfg_speed_span, cfg_speed_offset);
      angle_set = window_setting(angle_total, cfg_angle_span, cfg_angle_offset);
      magnitude = (speed_set < 0) ? -speed_set : speed_set;

      motor_ticks = (magnitude * longint'(cfg_motor_span)) / SPEED_FULL;
      // Signed division truncates toward zero when the angle is below -90.
      servo_ticks = ((angle_set + SERVO_ANGLE_SHIFT) * longint'(cfg_servo_span)) / ANGLE_FULL
                    + longint'(cfg_servo_base);

      outcome.speed_value     = 8'(speed_set);
      outcome.speed_magnitude = 7'(magnitude);
      outcome.angle_value     = 8'(angle_set);
      outcome.angle_unsigned  = 8'(angle_set + cfg_angle_offset);
      outcome.motor_pulse     = 16'(motor_ticks);
      outcome.servo_pulse     = 16'(servo_ticks);
      outcome.bridge_drive    = (speed_set > 0) ? DRIVE_POSITIVE :
                                (speed_set < 0) ? DRIVE_NEGATIVE : DRIVE_STOP;
      return outcome;
   endfunction

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s expected %0d got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // ---------------------------------------------------------------------
   // Monitor: sample both channels and the register port at the rising edge.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      pwm_result_type want;
      req_taken <= req_valid && req_ready;
      rsp_taken <= rsp_valid && rsp_ready;

      if (reset) begin
         load_defaults();
      end else begin
         // Compare a finished result against the oldest expectation.
         if (rsp_valid && rsp_ready) begin
            if (pending_outputs.size() == 0) begin
               $error("rsp transaction with no request pending");
               mismatch_count++;
            end else begin
               want = pending_outputs.pop_front();
               check_field("speed_value", want.speed_value, rsp_speed_value);
               check_field("speed_magnitude", want.speed_magnitude, rsp_speed_magnitude);
               check_field("angle_value", want.angle_value, rsp_angle_value);
               check_field("angle_unsigned", want.angle_unsigned, rsp_angle_unsigned);
               check_field("motor_pulse", want.motor_pulse, rsp_motor_pulse);
               check_field("servo_pulse", want.servo_pulse, rsp_servo_pulse);
               check_field("bridge_drive", want.bridge_drive, rsp_bridge_drive);
            end
         end

         // Predict each accepted request in acceptance order.
         if (req_valid && req_ready)
            pending_outputs.push_back(average_to_pwm(req_speed_sample, req_angle_sample));

         // Mirror register writes; unknown indexes leave everything unchanged.
         if (csr_write_enable) begin
            case (csr_index)
               CSR_SPEED_SPAN:      cfg_speed_span   = int'(csr_write_data[7:0]);
               CSR_SPEED_OFFSET:    cfg_speed_offset = int'(csr_write_data[6:0]);
               CSR_ANGLE_SPAN:      cfg_angle_span   = int'(csr_write_data[7:0]);
               CSR_ANGLE_OFFSET:    cfg_angle_offset = int'(csr_write_data[6:0]);
               CSR_MOTOR_TICK_SPAN: cfg_motor_span   = int'(csr_write_data);
               CSR_SERVO_TICK_SPAN: cfg_servo_span   = int'(csr_write_data);
               CSR_SERVO_TICK_BASE: cfg_servo_base   = int'(csr_write_data);
               default: ;
            endcase
         end
      end

      // Watchdog: count cycles in which no port moves anything.
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   // ---------------------------------------------------------------------
   // Request driver: walk the stimulus script at the falling edge.
   // ---------------------------------------------------------------------
   int gap_left   = 0;
   bit gap_loaded = 1'b0;

   always @(negedge clock) begin : request_driver
      logic     hold_valid;
      logic     write_now;
      step_type head;
      // Hold valid and payload until the transaction is taken.
      hold_valid = req_valid && !req_taken;
      write_now  = 1'b0;

      if (pending_outputs.size() == 0)
         drained_cycles = drained_cycles + 1;
      else
         drained_cycles = 0;

      if (!reset && !hold_valid && stimulus.size() > 0) begin
         head = stimulus[0];
         case (head.kind)
            STEP_SAMPLE: begin
               // Wait out this item's idle gap, then present it.
               if (!gap_loaded) begin
                  gap_left   = head.gap;
                  gap_loaded = 1'b1;
               end
               if (gap_left > 0) begin
                  gap_left = gap_left - 1;
               end else begin
                  hold_valid       = 1'b1;
                  req_speed_sample <= head.speed;
                  req_angle_sample <= head.angle;
                  gap_loaded       = 1'b0;
                  void'(stimulus.pop_front());
               end
            end
            STEP_CSR: begin
               // Write only once the block has gone idle.
               if (drained_cycles >= SETTLE_CYCLES) begin
                  write_now      = 1'b1;
                  csr_index      <= head.index;
                  csr_write_data <= head.data;
                  void'(stimulus.pop_front());
               end
            end
            STEP_DRAIN: begin
               if (pending_outputs.size() == 0)
                  void'(stimulus.pop_front());
            end
            default: ;
         endcase
      end

      req_valid        <= hold_valid;
      csr_write_enable <= write_now;
   end

   // ---------------------------------------------------------------------
   // Response side: stall a random number of cycles after each transaction,
   // with occasional stretches of no stalls at all.
   // ---------------------------------------------------------------------
   int stall_left = 0;
   int rsp_seen   = 0;
   bit rsp_calm   = 1'b0;

   always @(negedge clock) begin : response_pacer
      if (rsp_taken) begin
         rsp_seen = rsp_seen + 1;
         if (rsp_seen % 40 == 0)
            rsp_calm = ($urandom_range(0, 2) == 0);
         stall_left = rsp_calm ? 0 : $urandom_range(0, 4);
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
      end
      rsp_ready <= !reset && (stall_left == 0);
   end

   // ---------------------------------------------------------------------
   // Script builders.
   // ---------------------------------------------------------------------
   task automatic push_sample(logic [SAMPLE_W-1:0] speed, logic [SAMPLE_W-1:0] angle, int gap);
      step_type s;
      s = '{kind: STEP_SAMPLE, speed: speed, angle: angle, gap: gap, index: '0, data: '0};
      stimulus.push_back(s);
   endtask

   task automatic push_csr(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      step_type s;
      s = '{kind: STEP_CSR, speed: '0, angle: '0, gap: 0, index: index, data: data};
      stimulus.push_back(s);
   endtask

   task automatic push_drain();
      step_type s;
      s = '{kind: STEP_DRAIN, speed: '0, angle: '0, gap: 0, index: '0, data: '0};
      stimulus.push_back(s);
   endtask

   // Register data biased toward the masking edges.
   function automatic logic [CSR_DATA_W-1:0] pick_reg_value();
      case ($urandom_range(0, 5))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'h00FF;
         3:       return 16'h007F;
         default: return 16'($urandom);
      endcase
   endfunction

   // Samples biased toward full scale, zero and mid-scale.
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 5))
         0:       return 10'd0;
         1:       return 10'd1023;
         2:       return 10'd512;
         default: return 10'($urandom_range(0, 1023));
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Script, reset and end of run.
   // ---------------------------------------------------------------------
   initial begin : run_control
      csr_index_type       reg_id;
      logic [SAMPLE_W-1:0] speed_level;
      logic [SAMPLE_W-1:0] angle_level;
      int                  run_left;
      bit                  phase_calm;
      bit                  timed_out;

      // Default configuration: fill both windows at full scale, then mix.
      repeat (10)
         push_sample(10'd1023, 10'd1023, $urandom_range(0, 4));
      push_sample(10'd1023, 10'd0, $urandom_range(0, 4));
      push_sample(10'd0, 10'd1023, $urandom_range(0, 4));
      push_sample(10'd512, 10'd512, $urandom_range(0, 4));
      push_sample(10'd1, 10'd1022, $urandom_range(0, 4));

      // High extreme: wide data masked to the register width, offsets cleared,
      // so both settings clamp at the top and the motor pulse wraps.
      push_csr(CSR_SPEED_SPAN, 16'hFFFF);
      push_csr(CSR_SPEED_OFFSET, 16'hFF80);
      push_csr(CSR_ANGLE_SPAN, 16'h00FF);
      push_csr(CSR_ANGLE_OFFSET, 16'h0080);
      push_csr(CSR_MOTOR_TICK_SPAN, 16'hFFFF);
      push_csr(CSR_SERVO_TICK_SPAN, 16'hFFFF);
      push_csr(CSR_SERVO_TICK_BASE, 16'hFFFF);
      push_csr(CSR_NO_REGISTER, 16'h1234);
      repeat (3)
         push_sample(10'd1023, 10'd1023, $urandom_range(0, 4));

      // Low extreme: zero spans and full offsets drive the angle below -90,
      // so the servo numerator goes negative.
      push_csr(CSR_SPEED_SPAN, 16'h0000);
      push_csr(CSR_SPEED_OFFSET, 16'h007F);
      push_csr(CSR_ANGLE_SPAN, 16'hFF00);
      push_csr(CSR_ANGLE_OFFSET, 16'hFFFF);
      push_csr(CSR_SERVO_TICK_BASE, 16'h0000);
      push_sample(10'd0, 10'd0, 0);
      push_sample(10'd1023, 10'd1023, 0);
      push_sample(10'd555, 10'd170, $urandom_range(0, 4));

      // Random phases, each under its own configuration.
      for (int phase = 0; phase < 7; phase++) begin
         if (phase == 3) begin
            push_csr(CSR_SPEED_SPAN, 16'(SPEED_SPAN_RST));
            push_csr(CSR_SPEED_OFFSET, 16'(SPEED_OFFSET_RST));
            push_csr(CSR_ANGLE_SPAN, 16'(ANGLE_SPAN_RST));
            push_csr(CSR_ANGLE_OFFSET, 16'(ANGLE_OFFSET_RST));
            push_csr(CSR_MOTOR_TICK_SPAN, 16'(MOTOR_TICK_SPAN_RST));
            push_csr(CSR_SERVO_TICK_SPAN, 16'(SERVO_TICK_SPAN_RST));
            push_csr(CSR_SERVO_TICK_BASE, 16'(SERVO_TICK_BASE_RST));
         end else begin
            reg_id = reg_id.first();
            repeat (reg_id.num()) begin
               push_csr(reg_id, pick_reg_value());
               reg_id = reg_id.next();
            end
         end
         if ($urandom_range(0, 1) == 1)
            push_csr(CSR_NO_REGISTER, pick_reg_value());

         phase_calm = ($urandom_range(0, 3) == 0);
         run_left   = 0;
         for (int n = 0; n < 100; n++) begin
            // Runs of a steady level settle the window; jitter keeps it moving.
            if (run_left == 0) begin
               speed_level = pick_sample();
               angle_level = pick_sample();
               run_left    = $urandom_range(1, 12);
            end
            run_left = run_left - 1;
            push_sample(($urandom_range(0, 1) == 1) ? speed_level : pick_sample(),
                        ($urandom_range(0, 1) == 1) ? angle_level : pick_sample(),
                        phase_calm ? 0 : $urandom_range(0, 4));
            // Hold the sender once mid-phase until every result is back.
            if (phase == 2 && n == 50)
               push_drain();
         end
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Advance until the script is spent and every result has arrived.
      timed_out = 1'b0;
      while (!timed_out && (stimulus.size() != 0 || req_valid || pending_outputs.size() != 0)) begin
         @(posedge clock);
         if (quiet_cycles >= STALL_LIMIT)
            timed_out = 1'b1;
      end

      if (timed_out) begin
         $display("FAILURE");
      end else begin
         repeat (TAIL_CYCLES) @(posedge clock);
         if (mismatch_count == 0 && pending_outputs.size() == 0)
            $display("SUCCESS");
         else
            $display("FAILURE");
      end
      $finish;
   end

endmodule
